### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the Metaphone encoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define MCE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define MCE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    `MCE_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

// An implication whose consequent is checked in the next cycle.
`define MCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    `MCE_ASSERT(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

### sv/mce_pkg.sv
// ----------------------------------------------------------------------------
// Metaphone encoder package
// Widths, letter constants and the types shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mce_pkg;

    localparam int CHAR_W    = 8;
    localparam int RES_DEPTH = 3;

    localparam logic [CHAR_W-1:0]   CHAR_NONE = 8'h00;
    localparam logic [CHAR_W-1:0]   CODE_TH   = "0";
    localparam logic [CHAR_W-1:0]   CASE_GAP  = 8'd32;

    localparam logic [2*CHAR_W-1:0] PAIR_KN = "KN";
    localparam logic [2*CHAR_W-1:0] PAIR_GN = "GN";
    localparam logic [2*CHAR_W-1:0] PAIR_PN = "PN";
    localparam logic [2*CHAR_W-1:0] PAIR_AE = "AE";
    localparam logic [2*CHAR_W-1:0] PAIR_WR = "WR";

    typedef logic [RES_DEPTH-1:0][CHAR_W-1:0] t_win;

    typedef struct packed {
        logic [1:0]        cnt;
        logic [CHAR_W-1:0] prev;
        logic [1:0]        pos;
        logic [1:0]        skip;
    } t_ctrl;

    typedef struct packed {
        logic [CHAR_W-1:0] code_char;
        logic              code_valid;
        logic              code_last;
    } t_result;

    typedef struct packed {
        t_result [RES_DEPTH-1:0] ent;
        logic [1:0]              num;
    } t_result_set;

endpackage

`default_nettype wire

### sv/mce_if.sv
// ----------------------------------------------------------------------------
// Encoder channels
// Valid/ready interfaces for the text byte input and the code result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface mce_char_if;
    logic                      valid;
    logic                      ready;
    logic [mce_pkg::CHAR_W-1:0] char_in;
    logic                      word_end;

    modport source (output valid, output char_in, output word_end, input ready);
    modport sink   (input valid, input char_in, input word_end, output ready);
endinterface

interface mce_code_if;
    logic                      valid;
    logic                      ready;
    logic [mce_pkg::CHAR_W-1:0] code_char;
    logic                      code_valid;
    logic                      code_last;

    modport source (output valid, output code_char, output code_valid, output code_last,
                    input ready);
    modport sink   (input valid, input code_char, input code_valid, input code_last,
                    output ready);
endinterface

`default_nettype wire

### sv/mce_step.sv
// ----------------------------------------------------------------------------
// Encoder step
// Takes one byte into the letter window and encodes the letters it releases.
// ----------------------------------------------------------------------------
`default_nettype none

module mce_step (
    input  wire logic [mce_pkg::CHAR_W-1:0] i_char,
    input  wire logic                       i_end,
    input  wire mce_pkg::t_win              i_win,
    input  wire mce_pkg::t_ctrl             i_ctrl,
    output mce_pkg::t_win                   o_win,
    output mce_pkg::t_ctrl                  o_ctrl,
    output mce_pkg::t_result_set            o_set
);

    typedef struct packed {
        logic [mce_pkg::CHAR_W-1:0] ch;
        mce_pkg::t_win              win;
        mce_pkg::t_ctrl             ctrl;
    } t_enc;

    function automatic logic is_vowel(input logic [mce_pkg::CHAR_W-1:0] c);
        return c inside {"A", "E", "I", "O", "U"};
    endfunction

    function automatic logic silent_pair(input logic [2*mce_pkg::CHAR_W-1:0] p);
        return (p == mce_pkg::PAIR_KN) || (p == mce_pkg::PAIR_GN) ||
               (p == mce_pkg::PAIR_PN) || (p == mce_pkg::PAIR_AE) ||
               (p == mce_pkg::PAIR_WR);
    endfunction

    function automatic t_enc encode_head(input mce_pkg::t_win w, input mce_pkg::t_ctrl s);
        t_enc                       r;
        logic                       has1;
        logic                       has2;
        logic                       first;
        logic [mce_pkg::CHAR_W-1:0] c;
        logic [mce_pkg::CHAR_W-1:0] n1;
        logic [mce_pkg::CHAR_W-1:0] n2;
        logic [mce_pkg::CHAR_W-1:0] ch;
        logic [1:0]                 skip;
        has1  = (s.cnt >= 2'd2);
        has2  = (s.cnt == 2'd3);
        first = (s.pos == 2'd0);
        c     = w[0];
        n1    = has1 ? w[1] : mce_pkg::CHAR_NONE;
        n2    = has2 ? w[2] : mce_pkg::CHAR_NONE;
        ch    = mce_pkg::CHAR_NONE;
        skip  = s.skip;

        if (s.skip != 2'd0) begin
            skip = s.skip - 2'd1;
        end else if (first && has1 && silent_pair({c, n1})) begin
            ch = mce_pkg::CHAR_NONE;
        end else if (first && c == "X") begin
            ch = "S";
        end else if (first && c == "W" && n1 == "H") begin
            ch   = "W";
            skip = 2'd1;
        end else if (c == s.prev && c != "C") begin
            ch = mce_pkg::CHAR_NONE;
        end else if (is_vowel(c)) begin
            if (first) begin
                ch = c;
            end
        end else begin
            case (c)
                "B": begin
                    if (!(!has1 && s.prev == "M")) begin
                        ch = "B";
                    end
                end
                "C": begin
                    if (n1 == "H") begin
                        ch   = "X";
                        skip = 2'd1;
                    end else if (n1 inside {"I", "E", "Y"}) begin
                        ch = "S";
                    end else begin
                        ch = "K";
                    end
                end
                "D": begin
                    if (n1 == "G" && (n2 inside {"E", "I", "Y"})) begin
                        ch   = "J";
                        skip = 2'd2;
                    end else begin
                        ch = "T";
                    end
                end
                "G": begin
                    if ((n1 == "H" || n1 == "N") && has1 && !has2) begin
                        ch = mce_pkg::CHAR_NONE;
                    end else if (n1 inside {"I", "E", "Y"}) begin
                        ch = "J";
                    end else begin
                        ch = "K";
                    end
                end
                "H": begin
                    if (is_vowel(s.prev)) begin
                        if (is_vowel(n1)) begin
                            ch = "H";
                        end
                    end else if (first) begin
                        ch = "H";
                    end
                end
                "K": begin
                    if (s.prev != "C") begin
                        ch = "K";
                    end
                end
                "P": begin
                    if (n1 == "H") begin
                        ch   = "F";
                        skip = 2'd1;
                    end else begin
                        ch = "P";
                    end
                end
                "Q": ch = "K";
                "S", "T": begin
                    if (n1 == "H") begin
                        ch   = (c == "S") ? 8'("X") : mce_pkg::CODE_TH;
                        skip = 2'd1;
                    end else if (n1 == "I" && (n2 == "O" || n2 == "A")) begin
                        ch   = "X";
                        skip = 2'd2;
                    end else begin
                        ch = c;
                    end
                end
                "V": ch = "F";
                "W", "Y": begin
                    if (is_vowel(n1)) begin
                        ch = c;
                    end
                end
                "Z": ch = "S";
                default: ch = c;
            endcase
        end

        r.ch        = ch;
        r.win[0]    = w[1];
        r.win[1]    = w[2];
        r.win[2]    = w[2];
        r.ctrl.cnt  = s.cnt - 2'd1;
        r.ctrl.prev = c;
        r.ctrl.pos  = (s.pos == 2'd3) ? s.pos : s.pos + 2'd1;
        r.ctrl.skip = skip;
        return r;
    endfunction

    logic [mce_pkg::CHAR_W-1:0]                     upper;
    logic                                           is_letter;
    mce_pkg::t_win                                  win_in;
    mce_pkg::t_ctrl                                 ctrl_in;
    t_enc                                           enc_a;
    t_enc                                           enc_b;
    t_enc                                           enc_c;
    logic [mce_pkg::RES_DEPTH-1:0][mce_pkg::CHAR_W-1:0] chars;
    mce_pkg::t_result_set                           set;
    logic [1:0]                                     num;

    always_comb begin
        upper = i_char;
        if (i_char inside {["a":"z"]}) begin
            upper = i_char - mce_pkg::CASE_GAP;
        end
        is_letter = upper inside {["A":"Z"]};

        win_in  = i_win;
        ctrl_in = i_ctrl;
        if (is_letter && i_ctrl.cnt != 2'd3) begin
            win_in[i_ctrl.cnt] = upper;
            ctrl_in.cnt        = i_ctrl.cnt + 2'd1;
        end

        enc_a = '{ch: mce_pkg::CHAR_NONE, win: win_in, ctrl: ctrl_in};
        if (is_letter && ctrl_in.cnt == 2'd3) begin
            enc_a = encode_head(win_in, ctrl_in);
        end
        enc_b = '{ch: mce_pkg::CHAR_NONE, win: enc_a.win, ctrl: enc_a.ctrl};
        if (i_end && enc_a.ctrl.cnt != 2'd0) begin
            enc_b = encode_head(enc_a.win, enc_a.ctrl);
        end
        enc_c = '{ch: mce_pkg::CHAR_NONE, win: enc_b.win, ctrl: enc_b.ctrl};
        if (i_end && enc_b.ctrl.cnt != 2'd0) begin
            enc_c = encode_head(enc_b.win, enc_b.ctrl);
        end

        chars = {enc_c.ch, enc_b.ch, enc_a.ch};
        set   = '0;
        num   = 2'd0;
        for (int k = 0; k < mce_pkg::RES_DEPTH; k++) begin
            if (chars[k] != mce_pkg::CHAR_NONE) begin
                set.ent[num] = '{code_char: chars[k], code_valid: 1'b1, code_last: 1'b0};
                num          = num + 2'd1;
            end
        end
        if (i_end) begin
            if (num == 2'd0) begin
                set.ent[0] = '{code_char: mce_pkg::CHAR_NONE, code_valid: 1'b0,
                               code_last: 1'b1};
                num        = 2'd1;
            end else begin
                set.ent[num - 2'd1].code_last = 1'b1;
            end
        end
        set.num = num;

        o_win  = enc_c.win;
        o_ctrl = enc_c.ctrl;
        if (i_end) begin
            o_ctrl = '0;
        end
        o_set = set;
    end

endmodule

`default_nettype wire

### sv/mce_out_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Holds the results of one input transaction and hands them out one by one.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mce_out_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire mce_pkg::t_result_set i_set,
    output logic                      o_can_load,
    mce_code_if.source                o_code_chan
);

    mce_pkg::t_result [mce_pkg::RES_DEPTH-1:0] r_ent;
    mce_pkg::t_result [mce_pkg::RES_DEPTH-1:0] n_ent;
    logic [1:0]                                r_cnt;
    logic [1:0]                                n_cnt;
    logic                                      take;

    assign take       = o_code_chan.valid && o_code_chan.ready;
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && take);

    assign o_code_chan.valid      = (r_cnt != 2'd0);
    assign o_code_chan.code_char  = r_ent[0].code_char;
    assign o_code_chan.code_valid = r_ent[0].code_valid;
    assign o_code_chan.code_last  = r_ent[0].code_last;

    always_comb begin
        n_ent = r_ent;
        n_cnt = r_cnt;
        if (i_load) begin
            n_ent = i_set.ent;
            n_cnt = i_set.num;
        end else if (take) begin
            n_ent[0] = r_ent[1];
            n_ent[1] = r_ent[2];
            n_cnt    = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `MCE_ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, i_load, (r_cnt == 2'd0) || (r_cnt == 2'd1 && take), "Results loaded over a queue that still holds results.")
    `MCE_ASSERT_IMPL(a_empty_code_ends, i_clk, i_rst_n, o_code_chan.valid && !o_code_chan.code_valid, o_code_chan.code_last && o_code_chan.code_char == mce_pkg::CHAR_NONE, "An empty result does not close its word.")
    `MCE_ASSERT_NEXT(a_drain_continues, i_clk, i_rst_n, take && r_cnt >= 2'd2, o_code_chan.valid, "The queue lost results while draining.")

endmodule

`default_nettype wire

### sv/metaphone_code_encoder_unit.sv
// ----------------------------------------------------------------------------
// Metaphone code encoder
// Streams text bytes in and emits the simplified Metaphone code of each word.
// ----------------------------------------------------------------------------
//   Channel      | Direction | Payload
//   i_char_chan  | in        | char_in[7:0], word_end
//   o_code_chan  | out       | code_char[7:0], code_valid, code_last
//
// One input transaction is taken per cycle while the input register can
// advance; it is registered, then encoded combinationally and loaded into
// the result queue, whose registers present its first result.
// A transaction that yields results waits in the input register until the
// queue has room; one yielding none passes at once.
// A word end yields up to three results, leaving one per cycle while ready.
// Reset is synchronous and clears the window count and word state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module metaphone_code_encoder_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mce_char_if.sink   i_char_chan,
    mce_code_if.source o_code_chan
);

    logic                       r_in_valid;
    logic [mce_pkg::CHAR_W-1:0] r_in_char;
    logic                       r_in_end;
    mce_pkg::t_win              r_win;
    mce_pkg::t_ctrl             r_ctrl;

    mce_pkg::t_win              n_win;
    mce_pkg::t_ctrl             n_ctrl;
    mce_pkg::t_result_set       step_set;
    logic                       can_load;
    logic                       advance;
    logic                       load;
    logic                       accept;

    assign advance           = r_in_valid && ((step_set.num == 2'd0) || can_load);
    assign load              = advance && (step_set.num != 2'd0);
    assign i_char_chan.ready = !r_in_valid || advance;
    assign accept            = i_char_chan.valid && i_char_chan.ready;

    mce_step u_step (
        .i_char (r_in_char),
        .i_end  (r_in_end),
        .i_win  (r_win),
        .i_ctrl (r_ctrl),
        .o_win  (n_win),
        .o_ctrl (n_ctrl),
        .o_set  (step_set)
    );

    mce_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_set       (step_set),
        .o_can_load  (can_load),
        .o_code_chan (o_code_chan)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_char <= i_char_chan.char_in;
            r_in_end  <= i_char_chan.word_end;
        end
        if (advance) begin
            r_win <= n_win;
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_ctrl     <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_ctrl <= n_ctrl;
            end
        end
    end

    `MCE_ASSERT(a_window_not_full, i_clk, i_rst_n, r_ctrl.cnt != 2'd3, "The letter window was left full between transactions.")
    `MCE_ASSERT_NEXT(a_word_end_clears, i_clk, i_rst_n, advance && r_in_end, r_ctrl == '0, "Word state was not cleared after a word end.")
    `MCE_ASSERT_IMPL(a_load_needs_room, i_clk, i_rst_n, load, can_load, "A transaction with results left while the queue was busy.")

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// Metaphone encoder testbench
// Drives text bytes into the encoder and checks every code result in
// order against a behavioural encoder held in a small scoreboard. Both
// channels idle at random, and the run holds a short directed part followed
// by randomly built words rich in the letter groups that the rules treat
// specially.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mce_pkg::*;

    localparam int TEXT_BYTES  = 310;
    localparam int IDLE_LIMIT  = 400;
    localparam int TAIL_CYCLES = 32;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_byte;

    class code_scoreboard;
        logic [CHAR_W-1:0] window [3];
        int                fill;
        logic [CHAR_W-1:0] prev_letter;
        logic [1:0]        position;
        logic [1:0]        skip;
        t_result           expected_codes [$];
        int                errors;

        function new();
            errors = 0;
            clear_word();
        endfunction

        function void clear_word();
            foreach (window[i]) window[i] = CHAR_NONE;
            fill        = 0;
            prev_letter = CHAR_NONE;
            position    = 2'd0;
            skip        = 2'd0;
        endfunction

        function int outstanding();
            return expected_codes.size();
        endfunction

        function bit is_vowel(logic [CHAR_W-1:0] c);
            return c == "A" || c == "E" || c == "I" || c == "O" || c == "U";
        endfunction

        function bit silent_start(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b);
            logic [2*CHAR_W-1:0] pair;
            pair = {a, b};
            return pair == PAIR_KN || pair == PAIR_GN || pair == PAIR_PN ||
                   pair == PAIR_AE || pair == PAIR_WR;
        endfunction

        // Encodes and retires the oldest letter of the window.
        function logic [CHAR_W-1:0] encode_oldest();
            logic              has1;
            logic              has2;
            logic              first;
            logic [CHAR_W-1:0] c;
            logic [CHAR_W-1:0] n1;
            logic [CHAR_W-1:0] n2;
            logic [CHAR_W-1:0] code;
            has1  = fill >= 2;
            has2  = fill >= 3;
            c     = window[0];
            n1    = has1 ? window[1] : CHAR_NONE;
            n2    = has2 ? window[2] : CHAR_NONE;
            first = position == 2'd0;
            code  = CHAR_NONE;
            if (skip != 2'd0) begin
                skip = skip - 2'd1;
            end else if (first && has1 && silent_start(c, n1)) begin
                code = CHAR_NONE;
            end else if (first && c == "X") begin
                code = "S";
            end else if (first && c == "W" && n1 == "H") begin
                code = "W";
                skip = 2'd1;
            end else if (c == prev_letter && c != "C") begin
                code = CHAR_NONE;
            end else if (is_vowel(c)) begin
                if (first) code = c;
            end else begin
                case (c)
                    "B": if (!(!has1 && prev_letter == "M")) code = "B";
                    "C": begin
                        if (n1 == "H") begin
                            code = "X";
                            skip = 2'd1;
                        end else if (n1 == "I" || n1 == "E" || n1 == "Y") begin
                            code = "S";
                        end else begin
                            code = "K";
                        end
                    end
                    "D": begin
                        if (n1 == "G" && (n2 == "E" || n2 == "I" || n2 == "Y")) begin
                            code = "J";
                            skip = 2'd2;
                        end else begin
                            code = "T";
                        end
                    end
                    "G": begin
                        if ((n1 == "H" || n1 == "N") && has1 && !has2) begin
                            code = CHAR_NONE;
                        end else if (n1 == "I" || n1 == "E" || n1 == "Y") begin
                            code = "J";
                        end else begin
                            code = "K";
                        end
                    end
                    "H": begin
                        if (is_vowel(prev_letter)) begin
                            if (is_vowel(n1)) code = "H";
                        end else if (first) begin
                            code = "H";
                        end
                    end
                    "K": if (prev_letter != "C") code = "K";
                    "P": begin
                        if (n1 == "H") begin
                            code = "F";
                            skip = 2'd1;
                        end else begin
                            code = "P";
                        end
                    end
                    "Q": code = "K";
                    "S", "T": begin
                        if (n1 == "H") begin
                            code = (c == "S") ? "X" : CODE_TH;
                            skip = 2'd1;
                        end else if (n1 == "I" && (n2 == "O" || n2 == "A")) begin
                            code = "X";
                            skip = 2'd2;
                        end else begin
                            code = c;
                        end
                    end
                    "V": code = "F";
                    "W", "Y": if (is_vowel(n1)) code = c;
                    "Z": code = "S";
                    default: code = c;
                endcase
            end
            prev_letter = c;
            if (position != 2'd3) position = position + 2'd1;
            window[0] = window[1];
            window[1] = window[2];
            fill--;
            return code;
        endfunction

        function void take_byte(logic [CHAR_W-1:0] raw, logic last);
            logic [CHAR_W-1:0] c;
            logic [CHAR_W-1:0] code;
            logic [CHAR_W-1:0] codes [$];
            t_result           item;
            c = raw;
            if (c >= "a" && c <= "z") c = c - CASE_GAP;
            if (c >= "A" && c <= "Z") begin
                if (fill < 3) begin
                    window[fill] = c;
                    fill++;
                end
                if (fill == 3) begin
                    code = encode_oldest();
                    if (code != CHAR_NONE) codes.push_back(code);
                end
            end
            if (last) begin
                while (fill > 0) begin
                    code = encode_oldest();
                    if (code != CHAR_NONE) codes.push_back(code);
                end
            end
            foreach (codes[i]) begin
                item.code_char  = codes[i];
                item.code_valid = 1'b1;
                item.code_last  = last && (i == codes.size() - 1);
                expected_codes.push_back(item);
            end
            if (last) begin
                if (codes.size() == 0) begin
                    item.code_char  = CHAR_NONE;
                    item.code_valid = 1'b0;
                    item.code_last  = 1'b1;
                    expected_codes.push_back(item);
                end
                clear_word();
            end
        endfunction

        function void check_code(t_result got);
            t_result want;
            if (expected_codes.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual char %h valid %b last %b",
                         $time, got.code_char, got.code_valid, got.code_last);
                return;
            end
            want = expected_codes.pop_front();
            if (got.code_char !== want.code_char) begin
                errors++;
                $display("%0t: code_char expected %h actual %h",
                         $time, want.code_char, got.code_char);
            end
            if (got.code_valid !== want.code_valid) begin
                errors++;
                $display("%0t: code_valid expected %b actual %b",
                         $time, want.code_valid, got.code_valid);
            end
            if (got.code_last !== want.code_last) begin
                errors++;
                $display("%0t: code_last expected %b actual %b",
                         $time, want.code_last, got.code_last);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mce_char_if char_ch ();
    mce_code_if code_ch ();

    metaphone_code_encoder_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_chan (char_ch),
        .o_code_chan (code_ch)
    );

    code_scoreboard board = new();
    int             bytes_sent   = 0;
    bit             sender_burst = 1'b0;
    bit             sink_burst   = 1'b0;
    int             idle_cycles  = 0;

    string letter_groups [] = '{"CH", "GH", "TH", "SH", "PH", "WH", "KN", "GN", "PN", "AE",
                                "WR", "DGE", "DGI", "DGY", "TIO", "TIA", "SIO", "SIA", "CK",
                                "MB", "CI", "CE", "CY", "GI", "GE", "GY", "X", "Q", "V", "Z",
                                "W", "Y", "H", "AHA", "LL", "CC", "GN", "EE"};

    always #5ns i_clk = ~i_clk;

    function automatic bit is_letter(logic [CHAR_W-1:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic logic [CHAR_W-1:0] pick_noise();
        logic [CHAR_W-1:0] b;
        do b = CHAR_W'($urandom_range(0, 255)); while (is_letter(b));
        return b;
    endfunction

    task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic last);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_ch.valid    <= 1'b1;
        char_ch.char_in  <= ch;
        char_ch.word_end <= last;
        do @(posedge i_clk); while (char_ch.ready !== 1'b1);
        board.take_byte(ch, last);
        bytes_sent++;
    endtask

    task automatic send_string(input string s, input bit end_on_last);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], end_on_last && i == s.len() - 1);
    endtask

    task automatic wait_drained();
        char_ch.valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_word();
        t_text_byte        word [$];
        t_text_byte        tb_byte;
        logic [CHAR_W-1:0] letters [$];
        string             grp;
        int                parts;
        sender_burst = $urandom_range(0, 3) == 0;
        if ($urandom_range(0, 14) == 0) begin
            send_byte(pick_noise(), 1'b1);
            return;
        end
        parts = $urandom_range(1, 4);
        repeat (parts) begin
            if ($urandom_range(0, 1) == 1) begin
                grp = letter_groups[$urandom_range(0, letter_groups.size() - 1)];
                for (int i = 0; i < grp.len(); i++) letters.push_back(grp[i]);
            end else begin
                letters.push_back(CHAR_W'($urandom_range("A", "Z")));
            end
        end
        foreach (letters[i]) begin
            if ($urandom_range(0, 11) == 0) begin
                tb_byte.ch   = pick_noise();
                tb_byte.last = 1'b0;
                word.push_back(tb_byte);
            end
            tb_byte.ch   = $urandom_range(0, 1) ? (letters[i] | CASE_GAP) : letters[i];
            tb_byte.last = 1'b0;
            word.push_back(tb_byte);
        end
        if ($urandom_range(0, 3) != 0) begin
            word[$].last = 1'b1;
        end else begin
            tb_byte.ch   = pick_noise();
            tb_byte.last = 1'b1;
            word.push_back(tb_byte);
        end
        foreach (word[i]) send_byte(word[i].ch, word[i].last);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((char_ch.valid && char_ch.ready) || (code_ch.valid && code_ch.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : code_sink
        t_result got;
        int      stall;
        int      taken;
        taken = 0;
        code_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (taken % 20 == 0) sink_burst = $urandom_range(0, 3) == 0;
            stall = sink_burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                code_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            code_ch.ready <= 1'b1;
            do @(posedge i_clk); while (code_ch.valid !== 1'b1);
            got.code_char  = code_ch.code_char;
            got.code_valid = code_ch.code_valid;
            got.code_last  = code_ch.code_last;
            board.check_code(got);
            taken++;
        end
    end

    initial begin : text_source
        bit paused;
        paused = 1'b0;
        char_ch.valid    <= 1'b0;
        char_ch.char_in  <= CHAR_NONE;
        char_ch.word_end <= 1'b0;
        i_rst_n          <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // An empty word, a word whose end gives nothing, a final GH, the silent
        // and altered first letters, DGE and TH, and a non-letter end.
        send_byte(8'hFF, 1'b1);
        send_string("OHIOU", 1'b1);
        send_string("sigh", 1'b1);
        send_string("Kn", 1'b1);
        send_string("xZ", 1'b1);
        send_string("wh", 1'b1);
        send_string("edge", 1'b1);
        send_string("tHiA", 1'b0);
        send_byte(8'h00, 1'b1);
        wait_drained();

        while (bytes_sent < TEXT_BYTES) begin
            if (!paused && bytes_sent >= TEXT_BYTES / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            send_random_word();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
